/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("concurrent assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("concurrent assertion failed");

`endif

/* sv/sacl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// shared widths, types and codes of the set-associative cache lookup block
// ----------------------------------------------------------------------------
package sacl_pkg;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int STAMP_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int IN_DATA_W  = ADDR_W + STAMP_W;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_PAD_W  = OUT_DATA_W - 1 - 4 * COUNT_W;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // access kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } back_state_t;

  // running statistics
  typedef struct packed {
    logic [COUNT_W-1:0] ld_misses;
    logic [COUNT_W-1:0] ld_hits;
    logic [COUNT_W-1:0] misses;
    logic [COUNT_W-1:0] hits;
  } counters_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic lookup;
  } back_status_t;

endpackage

/* sv/sacl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_front
// accepts access requests, splits the address into set index and tag
// ----------------------------------------------------------------------------
module sacl_front #(
  parameter int OFF_BITS = 6,
  parameter int IDX_BITS = 10,
  parameter int IDX_W    = 10,
  parameter int TAG_W    = 16,
  parameter int REQ_W    = 59
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sacl_pkg::IN_DATA_W-1:0] s_tdata,   // address, time_stamp
  input  logic                           s_tuser,   // mode
  output logic                           push_valid,
  input  logic                           push_ready,
  output logic [REQ_W-1:0]               push_data
);

  logic                         held;
  logic                         held_next;
  logic                         accept;
  logic                         mode_q;
  logic [TAG_W-1:0]             tag_q;
  logic [IDX_W-1:0]             set_q;
  logic [sacl_pkg::STAMP_W-1:0] stamp_q;
  logic [sacl_pkg::ADDR_W-1:0]  address;
  logic [IDX_W-1:0]             set_d;
  logic [TAG_W-1:0]             tag_d;

  // address split
  assign address = s_tdata[sacl_pkg::ADDR_W-1:0];
  assign set_d   = (IDX_BITS == 0) ? '0 : address[OFF_BITS +: IDX_W];
  assign tag_d   = address[sacl_pkg::ADDR_W-1 -: TAG_W];

  // one holding register toward the queue
  assign s_tready = !held || push_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (push_ready) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= s_tuser;
      tag_q   <= tag_d;
      set_q   <= set_d;
      stamp_q <= s_tdata[sacl_pkg::IN_DATA_W-1:sacl_pkg::ADDR_W];
    end
  end

  assign push_valid = held;
  assign push_data  = {mode_q, tag_q, set_q, stamp_q};

endmodule

/* sv/sacl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_fifo
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module sacl_fifo #(
  parameter int WIDTH = 59,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/sacl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_back
// set read-modify-write: tag match, lru victim choice, counters and result
// ----------------------------------------------------------------------------
module sacl_back #(
  parameter int SET_COUNT = 1024,
  parameter int WAY_COUNT = 4,
  parameter int IDX_W     = 10,
  parameter int TAG_W     = 16,
  parameter int REQ_W     = 59
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [REQ_W-1:0]                q_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata,
  output sacl_pkg::back_status_t          status
);

  localparam int STAMP_W   = sacl_pkg::STAMP_W;
  localparam int WAY_W     = 1 + TAG_W + STAMP_W;
  localparam int ROW_W     = WAY_COUNT * WAY_W;
  localparam int WAY_IDX_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int PAD       = 1 << $clog2(WAY_COUNT);

  sacl_pkg::back_state_t state;
  sacl_pkg::back_state_t state_next;
  logic [IDX_W-1:0]      clr_cnt;
  logic [IDX_W-1:0]      clr_cnt_next;

  // queue entry fields
  logic                  q_mode;
  logic [TAG_W-1:0]      q_tag;
  logic [IDX_W-1:0]      q_set;
  logic [STAMP_W-1:0]    q_stamp;

  // request under lookup
  logic                  req_mode;
  logic [TAG_W-1:0]      req_tag;
  logic [IDX_W-1:0]      req_set;
  logic [STAMP_W-1:0]    req_stamp;

  // set memory, one row holds all ways of a set
  logic [ROW_W-1:0]      row_mem [SET_COUNT];
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      new_row;
  logic [ROW_W-1:0]      wr_data;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;
  logic                  rd_en;

  // per-way view of the row
  logic [WAY_COUNT-1:0]  way_valid;
  logic [TAG_W-1:0]      way_tag   [WAY_COUNT];
  logic [STAMP_W-1:0]    way_stamp [WAY_COUNT];
  logic [WAY_COUNT-1:0]  hit_vec;
  logic                  hit;
  logic                  any_inv;
  logic [WAY_IDX_W-1:0]  hit_way;
  logic [WAY_IDX_W-1:0]  inv_way;
  logic [WAY_IDX_W-1:0]  victim;

  // min-stamp tree, leaves at PAD and up
  logic [STAMP_W-1:0]    node_stamp [2*PAD];
  logic [WAY_IDX_W-1:0]  node_way   [2*PAD];

  sacl_pkg::counters_t   cnt;
  sacl_pkg::counters_t   cnt_upd;
  logic                  out_valid;
  logic                  out_load;
  logic [sacl_pkg::OUT_DATA_W-1:0] out_data;

  // queue entry unpacking
  assign q_mode  = q_data[REQ_W-1];
  assign q_tag   = q_data[REQ_W-2 -: TAG_W];
  assign q_set   = q_data[STAMP_W +: IDX_W];
  assign q_stamp = q_data[STAMP_W-1:0];

  // way fields and tag compare
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      way_valid[w] = rd_row[w*WAY_W + WAY_W - 1];
      way_tag[w]   = rd_row[w*WAY_W + STAMP_W +: TAG_W];
      way_stamp[w] = rd_row[w*WAY_W +: STAMP_W];
      hit_vec[w]   = way_valid[w] && (way_tag[w] == req_tag);
    end
  end

  // first hit way and first invalid way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_IDX_W'(w);
      end
      if (!way_valid[w]) begin
        inv_way = WAY_IDX_W'(w);
      end
    end
  end

  assign hit     = |hit_vec;
  assign any_inv = !(&way_valid);

  // smallest stamp, lower way wins ties
  always_comb begin
    for (int n = 0; n < 2 * PAD; n++) begin
      node_stamp[n] = '1;
      node_way[n]   = '0;
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      node_stamp[PAD + w] = way_stamp[w];
      node_way[PAD + w]   = WAY_IDX_W'(w);
    end
    for (int n = PAD - 1; n >= 1; n--) begin
      if (node_stamp[2*n] <= node_stamp[2*n + 1]) begin
        node_stamp[n] = node_stamp[2*n];
        node_way[n]   = node_way[2*n];
      end else begin
        node_stamp[n] = node_stamp[2*n + 1];
        node_way[n]   = node_way[2*n + 1];
      end
    end
  end

  // victim: first invalid way, else oldest stamp below now, else way 0
  always_comb begin
    if (any_inv) begin
      victim = inv_way;
    end else if (node_stamp[1] < req_stamp) begin
      victim = node_way[1];
    end else begin
      victim = '0;
    end
  end

  // updated row
  always_comb begin
    new_row = rd_row;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (hit && (hit_way == WAY_IDX_W'(w))) begin
        new_row[w*WAY_W +: STAMP_W] = req_stamp;
      end else if (!hit && (victim == WAY_IDX_W'(w))) begin
        new_row[w*WAY_W +: WAY_W] = {1'b1, req_tag, req_stamp};
      end
    end
  end

  // counter update
  always_comb begin
    cnt_upd = cnt;
    if (hit) begin
      cnt_upd.hits = cnt.hits + 1'b1;
      if (req_mode == sacl_pkg::MODE_LOAD) begin
        cnt_upd.ld_hits = cnt.ld_hits + 1'b1;
      end
    end else begin
      cnt_upd.misses = cnt.misses + 1'b1;
      if (req_mode == sacl_pkg::MODE_LOAD) begin
        cnt_upd.ld_misses = cnt.ld_misses + 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    q_ready      = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = req_set;
    wr_data      = new_row;
    out_load     = 1'b0;
    case (state)
      sacl_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '0;
        if (clr_cnt == IDX_W'(SET_COUNT - 1)) begin
          state_next = sacl_pkg::ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end
      sacl_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          rd_en      = 1'b1;
          state_next = sacl_pkg::ST_LOOKUP;
        end
      end
      sacl_pkg::ST_LOOKUP: begin
        if (!out_valid || m_tready) begin
          wr_en      = 1'b1;
          out_load   = 1'b1;
          state_next = sacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sacl_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sacl_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      if (out_load) begin
        cnt       <= cnt_upd;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture on pop
  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_mode  <= q_mode;
      req_tag   <= q_tag;
      req_set   <= q_set;
      req_stamp <= q_stamp;
    end
  end

  // set memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_row <= row_mem[q_set];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {{sacl_pkg::OUT_PAD_W{1'b0}}, cnt_upd.ld_misses, cnt_upd.ld_hits,
                   cnt_upd.misses, cnt_upd.hits, !hit};
    end
  end

  assign m_tvalid        = out_valid;
  assign m_tdata         = out_data;
  assign status.clearing = (state == sacl_pkg::ST_CLEAR);
  assign status.lookup   = (state == sacl_pkg::ST_LOOKUP);

endmodule

/* sv/set_assoc_cache_lru_lookup.sv */
// a request passes the front holding register, the queue, the back's request and row
// registers and the result register; the back takes no new request until it has
// written back the set row of the last one; the queue and front register absorb up to
// 3 requests while the back is busy; reset is synchronous; afterwards a clearing pass
// writes every set row before the first lookup; counters start at zero
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// tag-only set-associative cache with timestamp lru replacement and hit/miss counters
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_cache_lru_lookup #(
  parameter int LINE_BYTES = 64,
  parameter int SET_COUNT  = 1024,
  parameter int WAY_COUNT  = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sacl_pkg::IN_DATA_W-1:0]  s_tdata,   // address[31:0], time_stamp[63:32]
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sacl_pkg::OUT_DATA_W-1:0] m_tdata    // miss[0], hit_total[32:1],
                                                     // miss_total[64:33],
                                                     // load_hit_total[96:65],
                                                     // load_miss_total[128:97]
);

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS = $clog2(SET_COUNT);
  localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int TAG_W    = sacl_pkg::ADDR_W - OFF_BITS - IDX_BITS;
  localparam int REQ_W    = 1 + TAG_W + IDX_W + sacl_pkg::STAMP_W;

  logic                   push_valid;
  logic                   push_ready;
  logic [REQ_W-1:0]       push_data;
  logic                   q_valid;
  logic                   q_ready;
  logic [REQ_W-1:0]       q_data;
  sacl_pkg::back_status_t status;

  // request intake and address split
  sacl_front #(
    .OFF_BITS (OFF_BITS),
    .IDX_BITS (IDX_BITS),
    .IDX_W    (IDX_W),
    .TAG_W    (TAG_W),
    .REQ_W    (REQ_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  sacl_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (sacl_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // set lookup and update
  sacl_back #(
    .SET_COUNT (SET_COUNT),
    .WAY_COUNT (WAY_COUNT),
    .IDX_W     (IDX_W),
    .TAG_W     (TAG_W),
    .REQ_W     (REQ_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .status   (status)
  );

  // checks
  `ASSERT_IMPL(a_no_pop_in_clear, status.clearing, !(q_valid && q_ready))
  `ASSERT_NEXT(a_pop_starts_lookup, q_valid && q_ready, status.lookup)
  `ASSERT_NEXT(a_front_holds, push_valid && !push_ready, push_valid && $stable(push_data))
  `ASSERT_IMPL(a_result_from_lookup, $rose(m_tvalid), $past(status.lookup))

endmodule
